[design/dsd_pkg.sv]
package dsd_pkg;

   localparam int NUM_ENTRIES_DEF   = 64;
   localparam int MAX_ENTRY_LEN_DEF = 32;

   typedef enum logic [1:0] {
      KIND_BYTE = 2'd0,
      KIND_OK   = 2'd1,
      KIND_BAD  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      PH_COUNT = 2'd0,
      PH_LIT   = 2'd1,
      PH_ID    = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH_RD,
      ST_SEARCH_CMP,
      ST_EXP_RD,
      ST_EXP_OUT,
      ST_FINISH
   } back_state_type;

   typedef struct packed {
      logic        is_load;
      logic        slot_ok;
      logic [5:0]  slot;
      logic [31:0] tag;
      logic [7:0]  len;
      logic        off_ok;
      logic [4:0]  off;
      logic [7:0]  data;
      logic        last;
   } cmd_type;

endpackage

[design/dictionary_substitution_decompressor.sv]
// Channel   Direction  Handshake              Carries
// req_      in         req_valid/req_ready    one dictionary byte or one message byte
// rsp_      out        rsp_valid/rsp_ready    decoded byte or message status
// csr_      in         csr_valid/csr_ready    expected_length
//
// A loaded byte or a literal is handled as it leaves the queue; a 2-deep queue decouples intake.
// An entry id scans the tag memory slot by slot (up to 64 slots: read, compare),
// then each expanded byte is read through the registered byte memory port.
// Reset clears message state and slot valid bits; entry bytes are not cleared.
// A stalled rsp_ready holds the output register and backs up into the queue.
module dictionary_substitution_decompressor
   import dsd_pkg::*;
#(
   parameter int NUM_ENTRIES   = NUM_ENTRIES_DEF,
   parameter int MAX_ENTRY_LEN = MAX_ENTRY_LEN_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_mode,
   input  logic [5:0]  req_slot,
   input  logic [31:0] req_entry_id,
   input  logic [5:0]  req_entry_length,
   input  logic [4:0]  req_entry_offset,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_end_of_run,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_expected_length
);

   logic [31:0] expected_length_ff;
   logic        cmd_valid;
   cmd_type     cmd;
   logic        pop;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_length_ff <= 32'd0;
      end else if (csr_valid && csr_ready) begin
         expected_length_ff <= csr_expected_length;
      end
   end

   dsd_front #(
      .NUM_ENTRIES   (NUM_ENTRIES),
      .MAX_ENTRY_LEN (MAX_ENTRY_LEN)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_slot         (req_slot),
      .req_entry_id     (req_entry_id),
      .req_entry_length (req_entry_length),
      .req_entry_offset (req_entry_offset),
      .req_data_byte    (req_data_byte),
      .req_last         (req_last),
      .pop              (pop),
      .cmd_valid        (cmd_valid),
      .cmd              (cmd)
   );

   dsd_back #(
      .NUM_ENTRIES   (NUM_ENTRIES),
      .MAX_ENTRY_LEN (MAX_ENTRY_LEN)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .expected_length (expected_length_ff),
      .cmd_valid       (cmd_valid),
      .cmd             (cmd),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_end_of_run  (rsp_end_of_run)
   );

endmodule

[design/dsd_queue.sv]
module dsd_queue
   import dsd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    not_empty,
   output cmd_type head_cmd
);

   cmd_type    mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head_cmd  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

[design/dsd_front.sv]
module dsd_front
   import dsd_pkg::*;
#(
   parameter int NUM_ENTRIES   = NUM_ENTRIES_DEF,
   parameter int MAX_ENTRY_LEN = MAX_ENTRY_LEN_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_mode,
   input  logic [5:0]  req_slot,
   input  logic [31:0] req_entry_id,
   input  logic [5:0]  req_entry_length,
   input  logic [4:0]  req_entry_offset,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last,
   input  logic        pop,
   output logic        cmd_valid,
   output cmd_type     cmd
);

   localparam logic [7:0] MaxLen = 8'(MAX_ENTRY_LEN);

   cmd_type new_cmd;
   logic    full;
   logic    push;

   assign req_ready = !full;
   assign push      = req_valid && req_ready;

   always_comb begin
      new_cmd.is_load = !req_mode;
      new_cmd.slot_ok = (13'(req_slot) < 13'(NUM_ENTRIES));
      new_cmd.slot    = req_slot;
      new_cmd.tag     = req_entry_id;
      new_cmd.len     = ({2'b0, req_entry_length} > MaxLen) ? MaxLen
                                                            : {2'b0, req_entry_length};
      new_cmd.off_ok  = ({3'b0, req_entry_offset} < MaxLen);
      new_cmd.off     = req_entry_offset;
      new_cmd.data    = req_data_byte;
      new_cmd.last    = req_last;
   end

   dsd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (new_cmd),
      .full      (full),
      .pop       (pop),
      .not_empty (cmd_valid),
      .head_cmd  (cmd)
   );

endmodule

[design/dsd_back.sv]
module dsd_back
   import dsd_pkg::*;
#(
   parameter int NUM_ENTRIES   = NUM_ENTRIES_DEF,
   parameter int MAX_ENTRY_LEN = MAX_ENTRY_LEN_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [31:0] expected_length,
   input  logic        cmd_valid,
   input  cmd_type     cmd,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_end_of_run
);

   localparam int SLOTS = (NUM_ENTRIES < 64) ? NUM_ENTRIES : 64;
   localparam int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int LW    = $clog2(MAX_ENTRY_LEN + 1);
   localparam int BD    = SLOTS * MAX_ENTRY_LEN;
   localparam int AW    = (BD > 1) ? $clog2(BD) : 1;

   logic [31:0]   tag_mem  [SLOTS];
   logic [LW-1:0] len_mem  [SLOTS];
   logic [7:0]    byte_mem [BD];
   logic [31:0]   tag_q;
   logic [LW-1:0] len_q;
   logic [7:0]    byte_q;

   logic [SLOTS-1:0] vld_ff, vld_in;
   back_state_type   state_ff, state_in;
   phase_type        phase_ff, phase_in;
   logic [7:0]       lit_left_ff, lit_left_in;
   logic [1:0]       seen_ff, seen_in;
   logic [31:0]      acc_ff, acc_in;
   logic [31:0]      prod_ff, prod_in;
   logic             broken_ff, broken_in;
   logic             last_ff, last_in;
   logic [31:0]      id_ff, id_in;
   logic [IW-1:0]    scan_ff, scan_in;
   logic [LW-1:0]    len_ff, len_in;
   logic [LW-1:0]    k_ff, k_in;
   logic [AW-1:0]    base_ff, base_in;
   logic             out_valid_ff, out_valid_in;
   kind_type         out_kind_ff, out_kind_in;
   logic [7:0]       out_byte_ff, out_byte_in;
   logic             out_eor_ff, out_eor_in;

   logic          can_emit;
   logic [31:0]   room;
   logic [31:0]   id_val;
   logic          msg_pop;
   logic          cnt_bad;
   logic          id_full;
   logic          hit;
   logic          scan_end;
   logic          len_over;
   logic          tag_wr;
   logic          byte_wr;
   logic [IW-1:0] wr_idx;
   logic [AW-1:0] wr_addr;
   logic [LW-1:0] wr_len;

   assign can_emit = !out_valid_ff || rsp_ready;
   assign room     = (prod_ff >= expected_length) ? 32'd0 : expected_length - prod_ff;
   assign id_val   = {acc_ff[23:0], cmd.data};
   assign pop      = (state_ff == ST_IDLE) && cmd_valid && (cmd.is_load || can_emit);
   assign msg_pop  = pop && !cmd.is_load;
   assign cnt_bad  = !broken_ff && (phase_ff != PH_LIT) && (phase_ff != PH_ID)
                     && ({24'b0, cmd.data} > room);
   assign id_full  = !broken_ff && (phase_ff == PH_ID) && (seen_ff == 2'd3)
                     && (id_val != 32'd0);
   assign hit      = vld_ff[scan_ff] && (tag_q == id_ff);
   assign scan_end = (scan_ff == IW'(SLOTS - 1));
   assign len_over = (32'(len_q) > room);
   assign tag_wr   = pop && cmd.is_load && cmd.slot_ok;
   assign byte_wr  = tag_wr && cmd.off_ok;
   assign wr_idx   = IW'(cmd.slot);
   assign wr_addr  = AW'(cmd.slot) * AW'(MAX_ENTRY_LEN) + AW'(cmd.off);
   assign wr_len   = LW'(cmd.len);

   assign rsp_valid      = out_valid_ff;
   assign rsp_kind       = out_kind_ff;
   assign rsp_out_byte   = out_byte_ff;
   assign rsp_end_of_run = out_eor_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (msg_pop) begin
               if (id_full) begin
                  state_in = ST_SEARCH_RD;
               end else if (cmd.last && !broken_ff && !cnt_bad) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_SEARCH_RD: begin
            state_in = ST_SEARCH_CMP;
         end
         ST_SEARCH_CMP: begin
            if (hit) begin
               if (len_over) begin
                  if (can_emit) begin
                     state_in = ST_IDLE;
                  end
               end else if (len_q == '0) begin
                  state_in = last_ff ? ST_FINISH : ST_IDLE;
               end else begin
                  state_in = ST_EXP_RD;
               end
            end else if (!scan_end) begin
               state_in = ST_SEARCH_RD;
            end else if (can_emit) begin
               state_in = ST_IDLE;
            end
         end
         ST_EXP_RD: begin
            state_in = ST_EXP_OUT;
         end
         ST_EXP_OUT: begin
            if (can_emit) begin
               if (k_ff == len_ff - 1'b1) begin
                  state_in = last_ff ? ST_FINISH : ST_IDLE;
               end else begin
                  state_in = ST_EXP_RD;
               end
            end
         end
         ST_FINISH: begin
            if (can_emit) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      vld_in       = vld_ff;
      phase_in     = phase_ff;
      lit_left_in  = lit_left_ff;
      seen_in      = seen_ff;
      acc_in       = acc_ff;
      prod_in      = prod_ff;
      broken_in    = broken_ff;
      last_in      = last_ff;
      id_in        = id_ff;
      scan_in      = scan_ff;
      len_in       = len_ff;
      k_in         = k_ff;
      base_in      = base_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_kind_in  = out_kind_ff;
      out_byte_in  = out_byte_ff;
      out_eor_in   = out_eor_ff;

      if (tag_wr) begin
         vld_in[wr_idx] = 1'b1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (msg_pop) begin
               last_in = cmd.last;
               if (!broken_ff) begin
                  case (phase_ff)
                     PH_LIT: begin
                        out_valid_in = 1'b1;
                        out_kind_in  = KIND_BYTE;
                        out_byte_in  = cmd.data;
                        out_eor_in   = !cmd.last;
                        prod_in      = prod_ff + 32'd1;
                        lit_left_in  = lit_left_ff - 8'd1;
                        if (lit_left_ff == 8'd1) begin
                           phase_in = PH_ID;
                           seen_in  = 2'd0;
                           acc_in   = 32'd0;
                        end
                     end
                     PH_ID: begin
                        if (seen_ff == 2'd3) begin
                           phase_in = PH_COUNT;
                           seen_in  = 2'd0;
                           acc_in   = 32'd0;
                           id_in    = id_val;
                           scan_in  = '0;
                        end else begin
                           acc_in  = id_val;
                           seen_in = seen_ff + 2'd1;
                        end
                     end
                     default: begin
                        if (cnt_bad) begin
                           out_valid_in = 1'b1;
                           out_kind_in  = KIND_BAD;
                           out_byte_in  = 8'd0;
                           out_eor_in   = 1'b1;
                           broken_in    = 1'b1;
                        end else begin
                           lit_left_in = cmd.data;
                           seen_in     = 2'd0;
                           acc_in      = 32'd0;
                           phase_in    = (cmd.data == 8'd0) ? PH_ID : PH_LIT;
                        end
                     end
                  endcase
               end
               if (cmd.last && (broken_ff || cnt_bad)) begin
                  phase_in    = PH_COUNT;
                  lit_left_in = 8'd0;
                  seen_in     = 2'd0;
                  acc_in      = 32'd0;
                  prod_in     = 32'd0;
                  broken_in   = 1'b0;
               end
            end
         end
         ST_SEARCH_CMP: begin
            if (hit && !len_over) begin
               len_in  = len_q;
               k_in    = '0;
               base_in = AW'(scan_ff) * AW'(MAX_ENTRY_LEN);
            end else if (!hit && !scan_end) begin
               scan_in = scan_ff + 1'b1;
            end else if (can_emit) begin
               out_valid_in = 1'b1;
               out_kind_in  = KIND_BAD;
               out_byte_in  = 8'd0;
               out_eor_in   = 1'b1;
               broken_in    = !last_ff;
               if (last_ff) begin
                  phase_in    = PH_COUNT;
                  lit_left_in = 8'd0;
                  seen_in     = 2'd0;
                  acc_in      = 32'd0;
                  prod_in     = 32'd0;
               end
            end
         end
         ST_EXP_OUT: begin
            if (can_emit) begin
               out_valid_in = 1'b1;
               out_kind_in  = KIND_BYTE;
               out_byte_in  = byte_q;
               out_eor_in   = (k_ff == len_ff - 1'b1) && !last_ff;
               prod_in      = prod_ff + 32'd1;
               k_in         = k_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            if (can_emit) begin
               out_valid_in = 1'b1;
               out_kind_in  = ((((phase_ff == PH_ID) && (seen_ff == 2'd0))
                               || ((phase_ff != PH_ID) && (phase_ff != PH_LIT)))
                               && (prod_ff == expected_length)) ? KIND_OK : KIND_BAD;
               out_byte_in  = 8'd0;
               out_eor_in   = 1'b1;
               phase_in     = PH_COUNT;
               lit_left_in  = 8'd0;
               seen_in      = 2'd0;
               acc_in       = 32'd0;
               prod_in      = 32'd0;
               broken_in    = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         vld_ff       <= '0;
         phase_ff     <= PH_COUNT;
         lit_left_ff  <= 8'd0;
         seen_ff      <= 2'd0;
         acc_ff       <= 32'd0;
         prod_ff      <= 32'd0;
         broken_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vld_ff       <= vld_in;
         phase_ff     <= phase_in;
         lit_left_ff  <= lit_left_in;
         seen_ff      <= seen_in;
         acc_ff       <= acc_in;
         prod_ff      <= prod_in;
         broken_ff    <= broken_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff     <= last_in;
      id_ff       <= id_in;
      scan_ff     <= scan_in;
      len_ff      <= len_in;
      k_ff        <= k_in;
      base_ff     <= base_in;
      out_kind_ff <= out_kind_in;
      out_byte_ff <= out_byte_in;
      out_eor_ff  <= out_eor_in;
   end

   always_ff @(posedge clock) begin
      if (tag_wr) begin
         tag_mem[wr_idx] <= cmd.tag;
         len_mem[wr_idx] <= wr_len;
      end
      if (state_ff == ST_SEARCH_RD) begin
         tag_q <= tag_mem[scan_ff];
         len_q <= len_mem[scan_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (byte_wr) begin
         byte_mem[wr_addr] <= cmd.data;
      end
      if (state_ff == ST_EXP_RD) begin
         byte_q <= byte_mem[base_ff + AW'(k_ff)];
      end
   end

endmodule

[design/dsd_checker.sv]
module dsd_checker
   import dsd_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_kind,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_end_of_run
);

   a_no_rsp_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid)
      else $error("result shown right after reset");

   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_kind == KIND_BYTE || rsp_kind == KIND_OK || rsp_kind == KIND_BAD))
      else $error("illegal result kind");

   a_status_closes_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind != KIND_BYTE) |-> (rsp_end_of_run && rsp_out_byte == 8'd0))
      else $error("status item not last of run or carries a byte");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_kind)
                                     && $stable(rsp_out_byte) && $stable(rsp_end_of_run)))
      else $error("stalled result changed");

endmodule

bind dictionary_substitution_decompressor dsd_checker u_dsd_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_kind       (rsp_kind),
   .rsp_out_byte   (rsp_out_byte),
   .rsp_end_of_run (rsp_end_of_run)
);
